FILE: rtl/abs_sum_prox_box_bisect_core_macros.svh
// Assertion macros shared by the proximal-step bisection core.
// Needs nothing else; include it before the module that asserts.
`ifndef ABS_SUM_PROX_BOX_BISECT_CORE_MACROS_SVH
`define ABS_SUM_PROX_BOX_BISECT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASPBB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASPBB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/aspbb_pkg.sv
// Shared constants, codes and interface structs of the proximal-step core.
// Depends on nothing; the eval, control and top-level RTL files refer to it by scoped names.
package aspbb_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int GAMMA_W     = VALUE_WIDTH - 1;
   localparam int INDEX_W     = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = 2 * VALUE_WIDTH;
   localparam int CASE_W      = 3;
   localparam int TAG_W       = 2;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_MAX =
      {{(PROD_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_MIN =
      {{(PROD_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   // Request operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_GAMMA  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_BOUND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_BOUND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_INDEX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_INDEX = 3'd4;

   // Result case codes.
   localparam logic [CASE_W-1:0] CASE_SINGLE      = 3'd0;
   localparam logic [CASE_W-1:0] CASE_LOWER_BP    = 3'd1;
   localparam logic [CASE_W-1:0] CASE_LOWER_CLAMP = 3'd2;
   localparam logic [CASE_W-1:0] CASE_UPPER_BP    = 3'd3;
   localparam logic [CASE_W-1:0] CASE_UPPER_CLAMP = 3'd4;
   localparam logic [CASE_W-1:0] CASE_BISECT_HIT  = 3'd5;
   localparam logic [CASE_W-1:0] CASE_BISECT_INT  = 3'd6;

   // Result slots of the evaluation pipeline.
   localparam logic [TAG_W-1:0] SLOT_LOWER_IN  = 2'd0;
   localparam logic [TAG_W-1:0] SLOT_LOWER_OUT = 2'd1;
   localparam logic [TAG_W-1:0] SLOT_UPPER_OUT = 2'd2;
   localparam logic [TAG_W-1:0] SLOT_UPPER_IN  = 2'd3;
   localparam logic [TAG_W-1:0] SLOT_PROBE_LEFT = 2'd0;
   localparam logic [TAG_W-1:0] SLOT_PROBE_MID  = 2'd1;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } rd_req_type;

   typedef struct packed {
      logic                          valid;
      logic [TAG_W-1:0]              tag;
      logic                          test_neg;
      logic                          test_zero;
      logic signed [VALUE_WIDTH-1:0] shifted;
      logic signed [VALUE_WIDTH-1:0] bp;
   } eval_res_type;

   typedef struct packed {
      logic                          valid;
      logic signed [VALUE_WIDTH-1:0] solution;
      logic [CASE_W-1:0]             case_code;
   } done_type;

endpackage

FILE: rtl/aspbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the breakpoint and weight-sum tables.
module aspbb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/aspbb_eval.sv
// Evaluation pipeline: multiplies gamma by a weight sum, then forms the sign test
// and the rounded, saturated shifted value. Depends on aspbb_pkg.
module aspbb_eval (
   input  logic                                     clock,
   input  logic                                     reset,
   input  aspbb_pkg::rd_req_type                    issue,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] ws_rdata,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] bp_rdata,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] query_value,
   input  logic [aspbb_pkg::GAMMA_W-1:0]            gamma,
   output aspbb_pkg::eval_res_type                  res
);

   localparam int VW = aspbb_pkg::VALUE_WIDTH;
   localparam int PW = aspbb_pkg::PROD_W;

   // Stage 0 tracks the RAM read latency.
   logic                        s0_valid_ff, s0_valid_in;
   logic [aspbb_pkg::TAG_W-1:0] s0_tag_ff, s0_tag_in;

   // Stage 1 holds the product and the breakpoint.
   logic                        s1_valid_ff, s1_valid_in;
   logic [aspbb_pkg::TAG_W-1:0] s1_tag_ff, s1_tag_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [VW-1:0]        bp1_ff, bp1_in;
   logic signed [VW-1:0]        gamma_s;

   // Stage 2 holds the finished result.
   aspbb_pkg::eval_res_type     res_ff, res_in;
   logic signed [VW:0]          diff;
   logic signed [PW-1:0]        test_sum;
   logic signed [PW-1:0]        shift_sum;
   logic signed [PW-1:0]        rounded;
   logic signed [VW-1:0]        sat_val;

   assign s0_valid_in = issue.valid;
   assign s0_tag_in   = issue.tag;

   assign gamma_s     = signed'({1'b0, gamma});
   assign prod_in     = gamma_s * ws_rdata;
   assign bp1_in      = bp_rdata;
   assign s1_valid_in = s0_valid_ff;
   assign s1_tag_in   = s0_tag_ff;

   // The sign test is gamma*sigma + (u - v), both in Q32.32.
   assign diff      = {bp1_ff[VW-1], bp1_ff} - {query_value[VW-1], query_value};
   assign test_sum  = prod_ff + (PW'(diff) <<< aspbb_pkg::FRAC_BITS);
   assign shift_sum = (PW'(query_value) <<< aspbb_pkg::FRAC_BITS) - prod_ff;
   assign rounded   = (shift_sum + aspbb_pkg::ROUND_HALF) >>> aspbb_pkg::FRAC_BITS;

   always_comb begin
      if (rounded > aspbb_pkg::SAT_MAX) begin
         sat_val = aspbb_pkg::SAT_MAX[VW-1:0];
      end else if (rounded < aspbb_pkg::SAT_MIN) begin
         sat_val = aspbb_pkg::SAT_MIN[VW-1:0];
      end else begin
         sat_val = rounded[VW-1:0];
      end
   end

   always_comb begin
      res_in.valid     = s1_valid_ff;
      res_in.tag       = s1_tag_ff;
      res_in.test_neg  = test_sum[PW-1];
      res_in.test_zero = (test_sum == '0);
      res_in.shifted   = sat_val;
      res_in.bp        = bp1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         res_ff.valid <= res_in.valid;
      end
      s0_tag_ff        <= s0_tag_in;
      s1_tag_ff        <= s1_tag_in;
      prod_ff          <= prod_in;
      bp1_ff           <= bp1_in;
      res_ff.tag       <= res_in.tag;
      res_ff.test_neg  <= res_in.test_neg;
      res_ff.test_zero <= res_in.test_zero;
      res_ff.shifted   <= res_in.shifted;
      res_ff.bp        <= res_in.bp;
   end

   assign res = res_ff;

endmodule

FILE: rtl/aspbb_ctrl.sv
// Query sequencer: issues table reads for the edge tests and bisection probes,
// collects the evaluated results and decides the answer. Depends on aspbb_pkg.
`include "abs_sum_prox_box_bisect_core_macros.svh"

module aspbb_ctrl (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     query_start,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] query_value,
   input  logic [aspbb_pkg::IDX_W-1:0]              lower_index,
   input  logic [aspbb_pkg::IDX_W-1:0]              upper_index,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] lower_bound,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] upper_bound,
   input  aspbb_pkg::eval_res_type                  res,
   input  logic                                     out_free,
   output logic                                     busy,
   output aspbb_pkg::rd_req_type                    issue,
   output logic [aspbb_pkg::IDX_W-1:0]              ws_addr,
   output logic [aspbb_pkg::IDX_W-1:0]              bp_addr,
   output logic signed [aspbb_pkg::VALUE_WIDTH-1:0] query_hold,
   output aspbb_pkg::done_type                      done
);

   localparam int VW = aspbb_pkg::VALUE_WIDTH;
   localparam int IW = aspbb_pkg::IDX_W;
   localparam int NS = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_WAIT,
      ST_EDGE_DEC,
      ST_PROBE,
      ST_PROBE_B,
      ST_PROBE_DEC,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [aspbb_pkg::TAG_W-1:0] cnt_ff, cnt_in;
   logic [aspbb_pkg::TAG_W-1:0] last_tag_ff, last_tag_in;
   logic                        probe_ff, probe_in;
   logic [IW-1:0]               il_ff, il_in;
   logic [IW-1:0]               ir_ff, ir_in;
   logic [IW-1:0]               im_ff, im_in;
   logic signed [VW-1:0]        v_ff, v_in;
   logic signed [VW-1:0]        shv_il_ff, shv_il_in;
   logic signed [VW-1:0]        sol_ff, sol_in;
   logic [aspbb_pkg::CASE_W-1:0] code_ff, code_in;

   logic                        neg_ff [NS];
   logic                        neg_in [NS];
   logic                        zero_ff [NS];
   logic                        zero_in [NS];
   logic signed [VW-1:0]        shv_ff [NS];
   logic signed [VW-1:0]        shv_in [NS];
   logic signed [VW-1:0]        bpv_ff [NS];
   logic signed [VW-1:0]        bpv_in [NS];

   logic [IW:0]                 idx_sum;
   logic [IW-1:0]               im_calc;
   logic                        single;
   logic                        probe_go;
   logic signed [VW-1:0]        clamp_hi;
   logic signed [VW-1:0]        clamp_both;
   logic signed [VW-1:0]        clamp_lo_out;
   logic signed [VW-1:0]        clamp_hi_out;

   assign idx_sum  = {1'b0, il_ff} + {1'b0, ir_ff};
   assign im_calc  = idx_sum[IW:1];
   assign single   = ({1'b0, il_ff} == ({1'b0, ir_ff} + (IW+1)'(1)));
   assign probe_go = ({1'b0, ir_ff} > ({1'b0, il_ff} + (IW+1)'(1)));

   // Upper clamp goes first so that crossed bounds leave the lower bound.
   assign clamp_hi   = (shv_ff[aspbb_pkg::SLOT_UPPER_IN] > upper_bound) ?
                       upper_bound : shv_ff[aspbb_pkg::SLOT_UPPER_IN];
   assign clamp_both = (clamp_hi < lower_bound) ? lower_bound : clamp_hi;
   assign clamp_lo_out = (shv_ff[aspbb_pkg::SLOT_LOWER_OUT] < lower_bound) ?
                         lower_bound : shv_ff[aspbb_pkg::SLOT_LOWER_OUT];
   assign clamp_hi_out = clamp_hi;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      last_tag_in = last_tag_ff;
      probe_in    = probe_ff;
      il_in       = il_ff;
      ir_in       = ir_ff;
      im_in       = im_ff;
      v_in        = v_ff;
      shv_il_in   = shv_il_ff;
      sol_in      = sol_ff;
      code_in     = code_ff;
      for (int i = 0; i < NS; i++) begin
         neg_in[i]  = neg_ff[i];
         zero_in[i] = zero_ff[i];
         shv_in[i]  = shv_ff[i];
         bpv_in[i]  = bpv_ff[i];
      end
      issue.valid = 1'b0;
      issue.tag   = cnt_ff;
      ws_addr     = il_ff;
      bp_addr     = il_ff;

      // Evaluated tests land in the slot named by their tag.
      if (res.valid) begin
         neg_in[res.tag]  = res.test_neg;
         zero_in[res.tag] = res.test_zero;
         shv_in[res.tag]  = res.shifted;
         bpv_in[res.tag]  = res.bp;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               v_in     = query_value;
               il_in    = lower_index;
               ir_in    = upper_index;
               cnt_in   = aspbb_pkg::SLOT_LOWER_IN;
               probe_in = 1'b0;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            issue.valid = 1'b1;
            unique case (cnt_ff)
               aspbb_pkg::SLOT_LOWER_IN: begin
                  ws_addr = il_ff;
                  bp_addr = il_ff;
               end
               aspbb_pkg::SLOT_LOWER_OUT: begin
                  ws_addr = il_ff - IW'(1);
                  bp_addr = il_ff;
               end
               aspbb_pkg::SLOT_UPPER_OUT: begin
                  ws_addr = ir_ff - IW'(1);
                  bp_addr = ir_ff;
               end
               aspbb_pkg::SLOT_UPPER_IN: begin
                  ws_addr = ir_ff;
                  bp_addr = ir_ff;
               end
               default: begin
                  ws_addr = il_ff;
                  bp_addr = il_ff;
               end
            endcase
            cnt_in = cnt_ff + aspbb_pkg::TAG_W'(1);
            if (cnt_ff == aspbb_pkg::SLOT_UPPER_IN) begin
               last_tag_in = aspbb_pkg::SLOT_UPPER_IN;
               state_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (res.valid && (res.tag == last_tag_ff)) begin
               state_in = probe_ff ? ST_PROBE_DEC : ST_EDGE_DEC;
            end
         end
         ST_EDGE_DEC: begin
            state_in = ST_DONE;
            if (single) begin
               sol_in  = clamp_both;
               code_in = aspbb_pkg::CASE_SINGLE;
            end else if (!neg_ff[aspbb_pkg::SLOT_LOWER_IN]) begin
               if (neg_ff[aspbb_pkg::SLOT_LOWER_OUT] || zero_ff[aspbb_pkg::SLOT_LOWER_OUT]) begin
                  sol_in  = bpv_ff[aspbb_pkg::SLOT_LOWER_IN];
                  code_in = aspbb_pkg::CASE_LOWER_BP;
               end else begin
                  sol_in  = clamp_lo_out;
                  code_in = aspbb_pkg::CASE_LOWER_CLAMP;
               end
            end else if (neg_ff[aspbb_pkg::SLOT_UPPER_OUT] ||
                         zero_ff[aspbb_pkg::SLOT_UPPER_OUT]) begin
               if (!neg_ff[aspbb_pkg::SLOT_UPPER_IN]) begin
                  sol_in  = bpv_ff[aspbb_pkg::SLOT_UPPER_IN];
                  code_in = aspbb_pkg::CASE_UPPER_BP;
               end else begin
                  sol_in  = clamp_hi_out;
                  code_in = aspbb_pkg::CASE_UPPER_CLAMP;
               end
            end else begin
               // The lower-index test already carries v - gamma*sigma[il].
               shv_il_in = shv_ff[aspbb_pkg::SLOT_LOWER_IN];
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_go) begin
               issue.valid = 1'b1;
               issue.tag   = aspbb_pkg::SLOT_PROBE_LEFT;
               ws_addr     = im_calc - IW'(1);
               bp_addr     = im_calc;
               im_in       = im_calc;
               state_in    = ST_PROBE_B;
            end else begin
               sol_in   = shv_il_ff;
               code_in  = aspbb_pkg::CASE_BISECT_INT;
               state_in = ST_DONE;
            end
         end
         ST_PROBE_B: begin
            issue.valid = 1'b1;
            issue.tag   = aspbb_pkg::SLOT_PROBE_MID;
            ws_addr     = im_ff;
            bp_addr     = im_ff;
            probe_in    = 1'b1;
            last_tag_in = aspbb_pkg::SLOT_PROBE_MID;
            state_in    = ST_WAIT;
         end
         ST_PROBE_DEC: begin
            state_in = ST_PROBE;
            if (!neg_ff[aspbb_pkg::SLOT_PROBE_LEFT] && !zero_ff[aspbb_pkg::SLOT_PROBE_LEFT]) begin
               ir_in = im_ff;
            end else if (neg_ff[aspbb_pkg::SLOT_PROBE_MID]) begin
               il_in     = im_ff;
               shv_il_in = shv_ff[aspbb_pkg::SLOT_PROBE_MID];
            end else begin
               sol_in   = bpv_ff[aspbb_pkg::SLOT_PROBE_LEFT];
               code_in  = aspbb_pkg::CASE_BISECT_HIT;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         probe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         probe_ff <= probe_in;
      end
      cnt_ff      <= cnt_in;
      last_tag_ff <= last_tag_in;
      il_ff       <= il_in;
      ir_ff       <= ir_in;
      im_ff       <= im_in;
      v_ff        <= v_in;
      shv_il_ff   <= shv_il_in;
      sol_ff      <= sol_in;
      code_ff     <= code_in;
      for (int i = 0; i < NS; i++) begin
         neg_ff[i]  <= neg_in[i];
         zero_ff[i] <= zero_in[i];
         shv_ff[i]  <= shv_in[i];
         bpv_ff[i]  <= bpv_in[i];
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign query_hold     = v_ff;
   assign done.valid     = (state_ff == ST_DONE);
   assign done.solution  = sol_ff;
   assign done.case_code = code_ff;

   `ASPBB_ASSERT_IMP(a_res_while_busy, clock, reset, res.valid, state_ff != ST_IDLE,
      "evaluation result arrived with no query in progress")
   `ASPBB_ASSERT_IMP(a_probe_inside, clock, reset, state_ff == ST_PROBE_B,
      (im_ff > il_ff) && (im_ff < ir_ff), "bisection probe outside the open interval")
   `ASPBB_ASSERT_NXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && !out_free,
      (state_ff == ST_DONE) && $stable(sol_ff) && $stable(code_ff),
      "finished answer changed before hand-off")

endmodule

FILE: rtl/abs_sum_prox_box_bisect_core.sv
// Load requests write one table entry and are taken every cycle while idle.
// A query request reaches the result register when an edge test settles it or when
// bisection ends; each probe makes two table reads through the read, multiply, add
// pipeline, and a query makes 8 probes at most.
// The next request is taken the cycle after the answer enters the result register.
// Synchronous reset returns control and configuration to their defaults; the tables keep their data.
module abs_sum_prox_box_bisect_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_op,
   input  logic [aspbb_pkg::INDEX_W-1:0]            req_entry_index,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] req_breakpoint_value,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] req_weight_sum_value,
   input  logic signed [aspbb_pkg::VALUE_WIDTH-1:0] req_query_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [aspbb_pkg::VALUE_WIDTH-1:0] rsp_solution,
   output logic [aspbb_pkg::CASE_W-1:0]             rsp_case_code,
   input  logic                                     csr_write_enable,
   input  logic [aspbb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [aspbb_pkg::VALUE_WIDTH-1:0]        csr_write_data
);

   localparam int VW = aspbb_pkg::VALUE_WIDTH;
   localparam int IW = aspbb_pkg::IDX_W;

   logic [aspbb_pkg::GAMMA_W-1:0] gamma_ff, gamma_in;
   logic signed [VW-1:0]          lower_bound_ff, lower_bound_in;
   logic signed [VW-1:0]          upper_bound_ff, upper_bound_in;
   logic [IW-1:0]                 lower_index_ff, lower_index_in;
   logic [IW-1:0]                 upper_index_ff, upper_index_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]          rsp_solution_ff, rsp_solution_in;
   logic [aspbb_pkg::CASE_W-1:0]  rsp_code_ff, rsp_code_in;

   logic                          busy;
   logic                          req_take;
   logic                          load_wr;
   logic                          query_start;
   logic                          out_free;
   aspbb_pkg::rd_req_type         issue;
   aspbb_pkg::eval_res_type       res;
   aspbb_pkg::done_type           done;
   logic [IW-1:0]                 ws_addr;
   logic [IW-1:0]                 bp_addr;
   logic [VW-1:0]                 ws_rdata;
   logic [VW-1:0]                 bp_rdata;
   logic signed [VW-1:0]          query_hold;

   assign req_stall   = busy;
   assign req_take    = req_valid && !req_stall;
   assign load_wr     = req_take && (req_op == aspbb_pkg::OP_LOAD);
   assign query_start = req_take && (req_op == aspbb_pkg::OP_QUERY);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      gamma_in       = gamma_ff;
      lower_bound_in = lower_bound_ff;
      upper_bound_in = upper_bound_ff;
      lower_index_in = lower_index_ff;
      upper_index_in = upper_index_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            aspbb_pkg::CSR_STEP_GAMMA:  gamma_in = csr_write_data[aspbb_pkg::GAMMA_W-1:0];
            aspbb_pkg::CSR_LOWER_BOUND: lower_bound_in = signed'(csr_write_data);
            aspbb_pkg::CSR_UPPER_BOUND: upper_bound_in = signed'(csr_write_data);
            aspbb_pkg::CSR_LOWER_INDEX: lower_index_in = csr_write_data[IW-1:0];
            aspbb_pkg::CSR_UPPER_INDEX: upper_index_in = csr_write_data[IW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_solution_in = rsp_solution_ff;
      rsp_code_in     = rsp_code_ff;
      if (done.valid && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_solution_in = done.solution;
         rsp_code_in     = done.case_code;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff       <= aspbb_pkg::GAMMA_W'(65536);
         lower_bound_ff <= aspbb_pkg::SAT_MIN[VW-1:0];
         upper_bound_ff <= aspbb_pkg::SAT_MAX[VW-1:0];
         lower_index_ff <= IW'(1);
         upper_index_ff <= IW'(0);
         rsp_valid_ff   <= 1'b0;
      end else begin
         gamma_ff       <= gamma_in;
         lower_bound_ff <= lower_bound_in;
         upper_bound_ff <= upper_bound_in;
         lower_index_ff <= lower_index_in;
         upper_index_ff <= upper_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_solution_ff <= rsp_solution_in;
      rsp_code_ff     <= rsp_code_in;
   end

   aspbb_ram #(
      .WIDTH (VW),
      .DEPTH (aspbb_pkg::TABLE_DEPTH)
   ) u_bp_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_entry_index[IW-1:0]),
      .wr_data (req_breakpoint_value),
      .rd_en   (issue.valid),
      .rd_addr (bp_addr),
      .rd_data (bp_rdata)
   );

   aspbb_ram #(
      .WIDTH (VW),
      .DEPTH (aspbb_pkg::TABLE_DEPTH)
   ) u_ws_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_entry_index[IW-1:0]),
      .wr_data (req_weight_sum_value),
      .rd_en   (issue.valid),
      .rd_addr (ws_addr),
      .rd_data (ws_rdata)
   );

   aspbb_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .ws_rdata    (signed'(ws_rdata)),
      .bp_rdata    (signed'(bp_rdata)),
      .query_value (query_hold),
      .gamma       (gamma_ff),
      .res         (res)
   );

   aspbb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .query_start (query_start),
      .query_value (req_query_value),
      .lower_index (lower_index_ff),
      .upper_index (upper_index_ff),
      .lower_bound (lower_bound_ff),
      .upper_bound (upper_bound_ff),
      .res         (res),
      .out_free    (out_free),
      .busy        (busy),
      .issue       (issue),
      .ws_addr     (ws_addr),
      .bp_addr     (bp_addr),
      .query_hold  (query_hold),
      .done        (done)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_solution  = rsp_solution_ff;
   assign rsp_case_code = rsp_code_ff;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for abs_sum_prox_box_bisect_core: loads breakpoint tables,
// programs the step, box and index registers, and checks every query result.
// Depends on aspbb_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import aspbb_pkg::*;

   localparam longint VAL_HI        = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
   localparam longint VAL_LO        = -VAL_HI - 1;
   localparam longint ONE_Q         = longint'(1) <<< FRAC_BITS;
   localparam longint HALF_Q        = ONE_Q >>> 1;
   localparam int     IDLE_PCT      = 35;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     RANDOM_ITEMS  = 1450;
   localparam int     CYCLE_LIMIT   = 1500000;

   // Mirror of the block: tables, registers and the results still owed.
   class prox_scoreboard;
      longint                        bp_mem[TABLE_DEPTH];
      longint                        ws_mem[TABLE_DEPTH];
      longint                        step_gamma;
      longint                        lo_bound;
      longint                        hi_bound;
      int                            lo_idx;
      int                            hi_idx;
      logic signed [VALUE_WIDTH-1:0] expected_solutions[$];
      logic [CASE_W-1:0]             expected_cases[$];
      int                            failures;
      int                            loads;
      int                            queries;
      int                            code_seen[7];

      function new();
         step_gamma = ONE_Q;
         lo_bound   = VAL_LO;
         hi_bound   = VAL_HI;
         lo_idx     = 1;
         hi_idx     = 0;
      endfunction

      function int pending();
         return expected_solutions.size();
      endfunction

      function longint bp_at(int i);
         return bp_mem[i & (TABLE_DEPTH - 1)];
      endfunction

      function longint weight_at(int i);
         return ws_mem[i & (TABLE_DEPTH - 1)];
      endfunction

      // gamma * sigma[si] + (u[ui] - v), exact at 32 fraction bits.
      function longint gap_test(int si, int ui, longint v);
         return step_gamma * weight_at(si) + (bp_at(ui) - v) * ONE_Q;
      endfunction

      // v - gamma * sigma[si], rounded half up to Q16.16 and saturated.
      function longint moved_point(int si, longint v);
         longint t;
         t = v * ONE_Q - step_gamma * weight_at(si) + HALF_Q;
         t = t >>> FRAC_BITS;
         if (t > VAL_HI) t = VAL_HI;
         if (t < VAL_LO) t = VAL_LO;
         return t;
      endfunction

      function void set_config(logic [CSR_INDEX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
         case (idx)
            CSR_STEP_GAMMA:  step_gamma = longint'(data[GAMMA_W-1:0]);
            CSR_LOWER_BOUND: lo_bound = longint'($signed(data));
            CSR_UPPER_BOUND: hi_bound = longint'($signed(data));
            CSR_LOWER_INDEX: lo_idx = int'(data[INDEX_W-1:0]);
            CSR_UPPER_INDEX: hi_idx = int'(data[INDEX_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_WIDTH-1:0] bpv, logic [VALUE_WIDTH-1:0] wsv,
                                 logic [VALUE_WIDTH-1:0] qv);
         longint            v;
         longint            x;
         logic [CASE_W-1:0] code;
         int                il;
         int                ir;
         int                im;
         bit                hit;
         if (op == OP_LOAD) begin
            bp_mem[idx] = longint'($signed(bpv));
            ws_mem[idx] = longint'($signed(wsv));
            loads++;
            return;
         end
         queries++;
         v  = longint'($signed(qv));
         il = lo_idx;
         ir = hi_idx;
         if (il - 1 == ir) begin
            // Upper clamp first, so a crossed box ends on the lower bound.
            x = moved_point(ir, v);
            if (x > hi_bound) x = hi_bound;
            if (x < lo_bound) x = lo_bound;
            code = CASE_SINGLE;
         end else if (gap_test(il, il, v) >= 0) begin
            if (gap_test(il - 1, il, v) <= 0) begin
               x    = bp_at(il);
               code = CASE_LOWER_BP;
            end else begin
               x = moved_point(il - 1, v);
               if (x < lo_bound) x = lo_bound;
               code = CASE_LOWER_CLAMP;
            end
         end else if (gap_test(ir - 1, ir, v) <= 0) begin
            if (gap_test(ir, ir, v) >= 0) begin
               x    = bp_at(ir);
               code = CASE_UPPER_BP;
            end else begin
               x = moved_point(ir, v);
               if (x > hi_bound) x = hi_bound;
               code = CASE_UPPER_CLAMP;
            end
         end else begin
            hit = 1'b0;
            x   = 0;
            while (ir - il > 1 && !hit) begin
               im = (il + ir) / 2;
               if (gap_test(im - 1, im, v) > 0) begin
                  ir = im;
               end else if (gap_test(im, im, v) < 0) begin
                  il = im;
               end else begin
                  x   = bp_at(im);
                  hit = 1'b1;
               end
            end
            if (hit) begin
               code = CASE_BISECT_HIT;
            end else begin
               x    = moved_point(il, v);
               code = CASE_BISECT_INT;
            end
         end
         code_seen[code]++;
         expected_solutions.push_back(x[VALUE_WIDTH-1:0]);
         expected_cases.push_back(code);
      endfunction

      function void check_response(logic signed [VALUE_WIDTH-1:0] sol, logic [CASE_W-1:0] code);
         logic signed [VALUE_WIDTH-1:0] exp_sol;
         logic [CASE_W-1:0]             exp_code;
         if (expected_solutions.size() == 0) begin
            $display("%0t: result with no query waiting: solution %0d, case %0d",
                     $time, sol, code);
            failures++;
            return;
         end
         exp_sol  = expected_solutions.pop_front();
         exp_code = expected_cases.pop_front();
         if (sol !== exp_sol) begin
            $display("%0t: solution mismatch: expected %0d, actual %0d", $time, exp_sol, sol);
            failures++;
         end
         if (code !== exp_code) begin
            $display("%0t: case code mismatch: expected %0d, actual %0d",
                     $time, exp_code, code);
            failures++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset                = 1'b1;
   logic                          req_valid            = 1'b0;
   logic                          req_stall;
   logic                          req_op               = OP_LOAD;
   logic [INDEX_W-1:0]            req_entry_index      = '0;
   logic signed [VALUE_WIDTH-1:0] req_breakpoint_value = '0;
   logic signed [VALUE_WIDTH-1:0] req_weight_sum_value = '0;
   logic signed [VALUE_WIDTH-1:0] req_query_value      = '0;
   logic                          rsp_valid;
   logic                          rsp_stall            = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_solution;
   logic [CASE_W-1:0]             rsp_case_code;
   logic                          csr_write_enable     = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index            = CSR_STEP_GAMMA;
   logic [VALUE_WIDTH-1:0]        csr_write_data       = '0;

   prox_scoreboard sb = new();

   // Generated, sorted table contents; queries are aimed at them.
   longint gen_bp[TABLE_DEPTH];
   longint gen_ws[TABLE_DEPTH];
   int     cur_gap        = 16;
   bit     calm           = 1'b0;
   int     cycle_count    = 0;
   int     settings_count = 0;

   abs_sum_prox_box_bisect_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_entry_index      (req_entry_index),
      .req_breakpoint_value (req_breakpoint_value),
      .req_weight_sum_value (req_weight_sum_value),
      .req_query_value      (req_query_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_solution         (rsp_solution),
      .rsp_case_code        (rsp_case_code),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         sb.check_response(rsp_solution, rsp_case_code);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("abs_sum_prox_box_bisect_core regression: fail");
         $finish;
      end
   end

   // Presents one request and returns at the edge that accepts it.
   task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_WIDTH-1:0] bpv,
                               input logic [VALUE_WIDTH-1:0] wsv,
                               input logic [VALUE_WIDTH-1:0] qv);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= op;
      req_entry_index      <= idx;
      req_breakpoint_value <= bpv;
      req_weight_sum_value <= wsv;
      req_query_value      <= qv;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, idx, bpv, wsv, qv);
   endtask

   task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [VALUE_WIDTH-1:0] bpv,
                            input logic [VALUE_WIDTH-1:0] wsv);
      send_request(OP_LOAD, idx, bpv, wsv, $urandom());
   endtask

   task automatic send_query(input logic [VALUE_WIDTH-1:0] qv);
      send_request(OP_QUERY, INDEX_W'($urandom_range(TABLE_DEPTH - 1)), $urandom(), $urandom(),
                   qv);
   endtask

   // Waits until every result is back, then lets a trailing load finish.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [VALUE_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_config(idx, data);
   endtask

   task automatic program_settings(input logic [VALUE_WIDTH-1:0] gamma,
                                   input logic [VALUE_WIDTH-1:0] lb,
                                   input logic [VALUE_WIDTH-1:0] ub,
                                   input int li, input int ui);
      write_csr(CSR_STEP_GAMMA, gamma);
      write_csr(CSR_LOWER_BOUND, lb);
      write_csr(CSR_UPPER_BOUND, ub);
      write_csr(CSR_LOWER_INDEX, VALUE_WIDTH'(li));
      write_csr(CSR_UPPER_INDEX, VALUE_WIDTH'(ui));
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   // Sorted breakpoints and rising weight sums; equal neighbors can occur.
   task automatic fill_table(input int bits);
      longint b;
      longint w;
      b = -(longint'(1) <<< (bits + 6));
      w = -(longint'(1) <<< (bits + 6)) + longint'($urandom_range(1 << bits));
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         b = b + longint'($urandom_range((1 << bits) - 1));
         w = w + longint'($urandom_range((1 << bits) - 1));
         gen_bp[i] = b;
         gen_ws[i] = w;
         send_load(INDEX_W'(i), VALUE_WIDTH'(b), VALUE_WIDTH'(w));
      end
   endtask

   // Query value near the point where entry k's sign tests change.
   function automatic logic [VALUE_WIDTH-1:0] aim_at(input int k, input longint offset);
      longint v;
      v = gen_bp[k & (TABLE_DEPTH - 1)]
          + ((sb.step_gamma * gen_ws[k & (TABLE_DEPTH - 1)]) >>> FRAC_BITS) + offset;
      if (v > VAL_HI) v = VAL_HI;
      if (v < VAL_LO) v = VAL_LO;
      return v[VALUE_WIDTH-1:0];
   endfunction

   initial begin : stimulus
      int                     r;
      int                     k;
      int                     n;
      int                     lo;
      int                     hi;
      int                     li;
      int                     ui;
      int                     phase;
      int                     random_items;
      logic [VALUE_WIDTH-1:0] g;
      logic [VALUE_WIDTH-1:0] lb;
      logic [VALUE_WIDTH-1:0] ub;
      logic [VALUE_WIDTH-1:0] q;
      longint                 half_step;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before any query can read it.
      fill_table(cur_gap);
      half_step = longint'(1) <<< (cur_gap - 1);

      // Reset settings: a single interval around entry 0.
      send_query(32'h8000_0000);
      send_query(32'h7fff_ffff);
      send_query(32'h0000_0000);

      settle_block();
      program_settings(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 1, TABLE_DEPTH - 2);
      send_query(32'h8000_0000);
      send_query(32'h7fff_ffff);
      send_query(aim_at(1, 0));
      send_query(aim_at(TABLE_DEPTH - 2, 0));
      send_query(aim_at(100, 0));
      send_query(aim_at(100, half_step));

      // Crossed box in the single interval case: the lower bound wins.
      settle_block();
      program_settings(32'h0001_0000, 32'h03e8_0000, 32'hfc18_0000, 51, 50);
      send_query(32'h0000_0000);
      send_query(32'h7fff_ffff);

      // Crossed indices: no probe is made.
      settle_block();
      program_settings(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 200, 10);
      send_query(aim_at(100, 0));
      send_query(aim_at(200, half_step));

      // Upper index zero: its left neighbor wraps to the last entry.
      settle_block();
      program_settings(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 5, 0);
      send_query(aim_at(3, 0));
      send_query(32'h0000_0000);

      settle_block();
      program_settings(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 0, TABLE_DEPTH - 1);
      send_query(aim_at(128, 0));
      send_query(32'h8000_0000);

      // Zero step: the tests reduce to the sign of u - v.
      settle_block();
      program_settings(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, TABLE_DEPTH - 2);
      send_query(aim_at(50, 0));
      send_query(VALUE_WIDTH'(gen_bp[60] + 1));

      // Narrow box so that both edge clamps bite.
      settle_block();
      program_settings(32'h0001_0000, 32'hfff0_0000, 32'h0010_0000, 1, TABLE_DEPTH - 2);
      send_query(32'h8000_0000);
      send_query(32'h7fff_ffff);

      // Largest step, written with the unused top bit set.
      settle_block();
      program_settings(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, TABLE_DEPTH - 2);
      send_query(32'h0000_0000);
      send_query(32'h7fff_ffff);
      send_query(32'h8000_0000);

      // The total counts every request, the table refills included.
      random_items = sb.loads + sb.queries;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         settle_block();
         calm = (phase == 3);
         if (phase % 4 == 0) begin
            case ($urandom_range(3))
               0: cur_gap = 8;
               1: cur_gap = 16;
               2: cur_gap = 20;
               default: cur_gap = 22;
            endcase
            fill_table(cur_gap);
            random_items += TABLE_DEPTH;
            settle_block();
         end

         r = $urandom_range(99);
         if (r < 10)      g = 32'h0000_0001;
         else if (r < 20) g = 32'hffff_ffff;
         else if (r < 25) g = 32'h0000_0000;
         else if (r < 65) g = 32'h0001_0000;
         else if (r < 90) g = $urandom_range(1 << 20, 1 << 12);
         else             g = $urandom();

         r = $urandom_range(99);
         k = $urandom_range(200);
         if (r < 45) begin
            lb = 32'h8000_0000;
            ub = 32'h7fff_ffff;
         end else if (r < 75) begin
            lb = VALUE_WIDTH'(gen_bp[k]);
            ub = VALUE_WIDTH'(gen_bp[k + $urandom_range(55)]);
         end else if (r < 85) begin
            lb = VALUE_WIDTH'(gen_bp[k + 20]);
            ub = VALUE_WIDTH'(gen_bp[k]);
         end else begin
            lb = $urandom();
            ub = $urandom();
         end

         r = $urandom_range(99);
         if (r < 35) begin
            li = 1;
            ui = TABLE_DEPTH - 2;
         end else if (r < 60) begin
            li = $urandom_range(200, 1);
            ui = $urandom_range(TABLE_DEPTH - 2, li + 1);
         end else if (r < 72) begin
            ui = $urandom_range(TABLE_DEPTH - 2);
            li = ui + 1;
         end else if (r < 82) begin
            li = $urandom_range(TABLE_DEPTH - 1, 2);
            ui = $urandom_range(li - 2);
         end else if (r < 88) begin
            li = 0;
            ui = $urandom_range(TABLE_DEPTH - 1);
         end else if (r < 92) begin
            li = $urandom_range(TABLE_DEPTH - 1);
            ui = TABLE_DEPTH - 1;
         end else begin
            li = $urandom_range(TABLE_DEPTH - 1);
            ui = $urandom_range(TABLE_DEPTH - 1);
         end
         program_settings(g, lb, ub, li, ui);

         lo = ((li < ui) ? li : ui) - 2;
         hi = ((li < ui) ? ui : li) + 2;
         if (lo < 0) lo = 0;
         if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;

         n = $urandom_range(140, 60);
         for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r == 0) begin
               // Hold off until the block has caught up.
               req_valid <= 1'b0;
               do @(posedge clock); while (sb.pending() != 0);
            end
            if (r < 85) begin
               k = $urandom_range(hi, lo);
               case ($urandom_range(9))
                  0: q = $urandom();
                  1: q = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
                  2, 3, 4: q = aim_at(k, 0);
                  default: q = aim_at(k, longint'($urandom_range(2 << cur_gap))
                                         - (longint'(1) <<< cur_gap));
               endcase
               send_query(q);
            end else if (r < 93) begin
               k = $urandom_range(TABLE_DEPTH - 1);
               send_load(INDEX_W'(k), VALUE_WIDTH'(gen_bp[k]), VALUE_WIDTH'(gen_ws[k]));
            end else begin
               // Noise: arbitrary contents leave the table unsorted.
               send_load(INDEX_W'($urandom_range(TABLE_DEPTH - 1)), $urandom(), $urandom());
            end
            random_items++;
         end
      end

      calm = 1'b0;
      settle_block();
      repeat (64) @(posedge clock);

      $display("%0d loads and %0d queries checked under %0d register settings",
               sb.loads, sb.queries, settings_count);
      $display("cases: single %0d, lower bp %0d, lower clamp %0d, upper bp %0d, %s %0d, %s %0d, %s %0d",
               sb.code_seen[CASE_SINGLE], sb.code_seen[CASE_LOWER_BP],
               sb.code_seen[CASE_LOWER_CLAMP], sb.code_seen[CASE_UPPER_BP],
               "upper clamp", sb.code_seen[CASE_UPPER_CLAMP],
               "bisection hit", sb.code_seen[CASE_BISECT_HIT],
               "bisection interval", sb.code_seen[CASE_BISECT_INT]);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("abs_sum_prox_box_bisect_core regression: pass");
      end else begin
         $display("abs_sum_prox_box_bisect_core regression: fail");
      end
      $finish;
   end

endmodule
